/* sv/epdm_pkg.sv */
`timescale 1ns / 1ps
// Package for the ESC pulse deadband mapper: widths, reset values, register
// indices, direction codes and the side-band record carried by the divider.
// No dependencies.
package epdm_pkg;

    localparam int PULSE_BITS     = 12;
    localparam int GAIN_FRAC_BITS = 14;
    localparam int GAIN_BITS      = 16;
    localparam int DZ_BITS        = 10;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 3;

    // offset magnitude times gain
    localparam int PROD_BITS  = PULSE_BITS + GAIN_BITS;
    // scaled magnitude after dropping the fraction
    localparam int SCALE_BITS = PROD_BITS - GAIN_FRAC_BITS;
    // neutral +/- scaled, signed
    localparam int SUM_BITS   = SCALE_BITS + 2;
    // map operands: x - a and span, signed
    localparam int OFF_BITS   = PULSE_BITS + 1;
    // map output span d - c, signed (a deadzone can push it below -max)
    localparam int SLOPE_BITS = PULSE_BITS + 2;
    // signed map product
    localparam int MAPP_BITS  = OFF_BITS + SLOPE_BITS;
    // magnitude of the map product, also the quotient width
    localparam int NUM_BITS   = 2 * PULSE_BITS + 1;
    // lower output bound c of the map, unsigned
    localparam int BASE_BITS  = PULSE_BITS + 1;
    // signed quotient plus base
    localparam int FIN_BITS   = NUM_BITS + 2;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN =
        (GAIN_FRAC_BITS >= GAIN_BITS) ? {GAIN_BITS{1'b1}} : GAIN_BITS'(1 << GAIN_FRAC_BITS);

    localparam logic [PULSE_BITS-1:0] RST_NEUTRAL = PULSE_BITS'(1500);
    localparam logic [PULSE_BITS-1:0] RST_MIN     = PULSE_BITS'(1000);
    localparam logic [PULSE_BITS-1:0] RST_MAX     = PULSE_BITS'(2000);

    localparam logic [CFG_IDX_BITS-1:0] REG_FWD_GAIN = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_REV_GAIN = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_FWD_DZ   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_REV_DZ   = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_NEUTRAL  = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN      = CFG_IDX_BITS'(5);
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX      = CFG_IDX_BITS'(6);

    localparam logic [1:0] DIR_NEUTRAL = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    typedef struct packed {
        logic [BASE_BITS-1:0] base;
        logic                 zero_span;
        logic                 neg_quot;
        logic [1:0]           dir;
    } epdm_side_t;

endpackage

/* sv/epdm_div.sv */
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side-band record carried alongside. Depends on epdm_pkg.
module epdm_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [epdm_pkg::NUM_BITS-1:0]   in_num,
    input  logic [epdm_pkg::PULSE_BITS-1:0] in_den,
    input  epdm_pkg::epdm_side_t            in_side,
    output logic                            out_valid,
    output logic [epdm_pkg::NUM_BITS-1:0]   out_quot,
    output epdm_pkg::epdm_side_t            out_side
);
    import epdm_pkg::*;

    logic                  valid_reg [NUM_BITS];
    logic [NUM_BITS-1:0]   num_reg   [NUM_BITS];
    epdm_side_t            side_reg  [NUM_BITS];
    logic [PULSE_BITS-1:0] rem_reg   [NUM_BITS-1];
    logic [PULSE_BITS-1:0] den_reg   [NUM_BITS-1];

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic                  valid_src;
        logic [NUM_BITS-1:0]   num_src;
        logic [PULSE_BITS-1:0] rem_src;
        logic [PULSE_BITS-1:0] den_src;
        epdm_side_t            side_src;
        logic [PULSE_BITS:0]   trial;
        logic                  fits;
        logic [NUM_BITS-1:0]   num_next;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign num_src   = in_num;
            assign rem_src   = '0;
            assign den_src   = in_den;
            assign side_src  = in_side;
        end else begin : g_rest
            assign valid_src = valid_reg[k-1];
            assign num_src   = num_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign side_src  = side_reg[k-1];
        end

        // shift in the next numerator bit, subtract when the divisor fits
        assign trial    = {rem_src, num_src[NUM_BITS-1]};
        assign fits     = (trial >= {1'b0, den_src});
        assign num_next = {num_src[NUM_BITS-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k]  <= num_next;
                side_reg[k] <= side_src;
            end
        end

        // the last stage keeps no remainder
        if (k < NUM_BITS - 1) begin : g_carry
            logic [PULSE_BITS:0]   diff;
            logic [PULSE_BITS-1:0] rem_next;

            assign diff     = trial - {1'b0, den_src};
            assign rem_next = fits ? diff[PULSE_BITS-1:0] : trial[PULSE_BITS-1:0];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_src;
                end
            end
        end
    end

    assign out_valid = valid_reg[NUM_BITS-1];
    assign out_quot  = num_reg[NUM_BITS-1];
    assign out_side  = side_reg[NUM_BITS-1];

endmodule

/* sv/esc_pulse_deadband_mapper_core.sv */
`timescale 1ns / 1ps
// Top level of the ESC pulse deadband mapper: gain scaling, clamp, deadzone
// remap and final clamp. Depends on epdm_pkg and epdm_div.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------
//  config   | cfg_wr_en             | cfg_index, cfg_wdata
//  input    | s_valid / s_ready     | s_target_us
//  result   | m_valid / m_ready     | m_pulse_us, m_direction
//
// One item per cycle sustained while results are taken; the pipeline has
// six arithmetic stages, one stage per quotient bit in the map divider,
// and the output register. The divider sets the depth.
// Reset clears the valid bits and loads the register defaults.
// The pipeline moves as one: while a result waits untaken, every stage holds.
module esc_pulse_deadband_mapper_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [epdm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [epdm_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [epdm_pkg::PULSE_BITS-1:0]    s_target_us,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [epdm_pkg::PULSE_BITS-1:0]    m_pulse_us,
    output logic [1:0]                         m_direction
);
    import epdm_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [GAIN_BITS-1:0]  fwd_gain_reg;
    logic [GAIN_BITS-1:0]  rev_gain_reg;
    logic [DZ_BITS-1:0]    fwd_dz_reg;
    logic [DZ_BITS-1:0]    rev_dz_reg;
    logic [PULSE_BITS-1:0] neutral_reg;
    logic [PULSE_BITS-1:0] min_reg;
    logic [PULSE_BITS-1:0] max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_gain_reg <= UNITY_GAIN;
            rev_gain_reg <= UNITY_GAIN;
            fwd_dz_reg   <= '0;
            rev_dz_reg   <= '0;
            neutral_reg  <= RST_NEUTRAL;
            min_reg      <= RST_MIN;
            max_reg      <= RST_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FWD_GAIN: fwd_gain_reg <= cfg_wdata[GAIN_BITS-1:0];
                REG_REV_GAIN: rev_gain_reg <= cfg_wdata[GAIN_BITS-1:0];
                REG_FWD_DZ:   fwd_dz_reg   <= cfg_wdata[DZ_BITS-1:0];
                REG_REV_DZ:   rev_dz_reg   <= cfg_wdata[DZ_BITS-1:0];
                REG_NEUTRAL:  neutral_reg  <= cfg_wdata[PULSE_BITS-1:0];
                REG_MIN:      min_reg      <= cfg_wdata[PULSE_BITS-1:0];
                REG_MAX:      max_reg      <= cfg_wdata[PULSE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the whole pipe steps unless the output is held.
    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------------------------------------------------------
    // Stage 1: offset magnitude from neutral and gain selection
    // ---------------------------------------------------------------
    logic                  s1_valid_reg;
    logic [PULSE_BITS-1:0] s1_mag_reg, s1_mag_next;
    logic [GAIN_BITS-1:0]  s1_gain_reg, s1_gain_next;
    logic                  s1_below_reg, s1_below_next;

    always_comb begin
        s1_below_next = (s_target_us < neutral_reg);
        s1_mag_next   = s1_below_next ? (neutral_reg - s_target_us)
                                      : (s_target_us - neutral_reg);
        s1_gain_next  = s1_below_next ? rev_gain_reg : fwd_gain_reg;
    end

    // ---------------------------------------------------------------
    // Stage 2: magnitude times gain (unsigned Q.14)
    // ---------------------------------------------------------------
    logic                 s2_valid_reg;
    logic [PROD_BITS-1:0] s2_prod_reg, s2_prod_next;
    logic                 s2_below_reg;

    assign s2_prod_next = PROD_BITS'(s1_mag_reg) * PROD_BITS'(s1_gain_reg);

    // ---------------------------------------------------------------
    // Stage 3: drop fraction (truncates toward zero), add to neutral, clamp
    // ---------------------------------------------------------------
    logic                  s3_valid_reg;
    logic [PULSE_BITS-1:0] s3_v_reg, s3_v_next;

    logic signed [SUM_BITS-1:0] neu_sum, scl_sum, sum3, lo_sum, hi_sum;

    always_comb begin
        neu_sum = signed'({{(SUM_BITS-PULSE_BITS){1'b0}}, neutral_reg});
        scl_sum = signed'({2'b00, s2_prod_reg[PROD_BITS-1:GAIN_FRAC_BITS]});
        lo_sum  = signed'({{(SUM_BITS-PULSE_BITS){1'b0}}, min_reg});
        hi_sum  = signed'({{(SUM_BITS-PULSE_BITS){1'b0}}, max_reg});
        sum3    = s2_below_reg ? (neu_sum - scl_sum) : (neu_sum + scl_sum);
        // min is tested first, so with min above max a sum below min yields min, any other max
        if (sum3 < lo_sum) begin
            s3_v_next = min_reg;
        end else if (sum3 > hi_sum) begin
            s3_v_next = max_reg;
        end else begin
            s3_v_next = sum3[PULSE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: pick the map side and form its operands
    //   reverse: map(v, min, neutral, min, neutral - rev_dz)
    //   forward: map(v, neutral, max, neutral + fwd_dz, max)
    // Neutral gives a zero span, so the map collapses to its base.
    // ---------------------------------------------------------------
    logic                        s4_valid_reg;
    logic signed [OFF_BITS-1:0]  s4_x_reg, s4_x_next;
    logic signed [OFF_BITS-1:0]  s4_span_reg, s4_span_next;
    logic signed [SLOPE_BITS-1:0] s4_slope_reg, s4_slope_next;
    logic [BASE_BITS-1:0]        s4_base_reg, s4_base_next;
    logic [1:0]                  s4_dir_reg, s4_dir_next;

    logic signed [OFF_BITS-1:0]   v_o, neu_o, lo_o, hi_o;
    logic signed [SLOPE_BITS-1:0] neu_w, lo_w, hi_w, fdz_w, rdz_w;

    always_comb begin
        v_o   = signed'({1'b0, s3_v_reg});
        neu_o = signed'({1'b0, neutral_reg});
        lo_o  = signed'({1'b0, min_reg});
        hi_o  = signed'({1'b0, max_reg});
        neu_w = signed'({2'b00, neutral_reg});
        lo_w  = signed'({2'b00, min_reg});
        hi_w  = signed'({2'b00, max_reg});
        fdz_w = signed'({{(SLOPE_BITS-DZ_BITS){1'b0}}, fwd_dz_reg});
        rdz_w = signed'({{(SLOPE_BITS-DZ_BITS){1'b0}}, rev_dz_reg});
        if (s3_v_reg < neutral_reg) begin
            s4_dir_next   = DIR_REVERSE;
            s4_x_next     = v_o - lo_o;
            s4_span_next  = neu_o - lo_o;
            s4_slope_next = neu_w - rdz_w - lo_w;
            s4_base_next  = {1'b0, min_reg};
        end else if (s3_v_reg > neutral_reg) begin
            s4_dir_next   = DIR_FORWARD;
            s4_x_next     = v_o - neu_o;
            s4_span_next  = hi_o - neu_o;
            s4_slope_next = hi_w - neu_w - fdz_w;
            s4_base_next  = BASE_BITS'(neutral_reg) + BASE_BITS'(fwd_dz_reg);
        end else begin
            s4_dir_next   = DIR_NEUTRAL;
            s4_x_next     = '0;
            s4_span_next  = '0;
            s4_slope_next = '0;
            s4_base_next  = {1'b0, neutral_reg};
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: signed map product (x - a) * (d - c)
    // ---------------------------------------------------------------
    logic                        s5_valid_reg;
    logic signed [MAPP_BITS-1:0] s5_prod_reg, s5_prod_next;
    logic signed [OFF_BITS-1:0]  s5_span_reg;
    logic [BASE_BITS-1:0]        s5_base_reg;
    logic [1:0]                  s5_dir_reg;

    assign s5_prod_next = MAPP_BITS'(s4_x_reg) * MAPP_BITS'(s4_slope_reg);

    // ---------------------------------------------------------------
    // Stage 6: sign and magnitude for the divider; truncation toward
    // zero follows from dividing magnitudes and applying the sign after.
    // ---------------------------------------------------------------
    logic                  s6_valid_reg;
    logic [NUM_BITS-1:0]   s6_num_reg, s6_num_next;
    logic [PULSE_BITS-1:0] s6_den_reg, s6_den_next;
    epdm_side_t            s6_side_reg, s6_side_next;

    logic signed [MAPP_BITS-1:0] prod_abs;
    logic signed [OFF_BITS-1:0]  span_abs;

    always_comb begin
        prod_abs    = s5_prod_reg[MAPP_BITS-1] ? -s5_prod_reg : s5_prod_reg;
        span_abs    = s5_span_reg[OFF_BITS-1] ? -s5_span_reg : s5_span_reg;
        s6_num_next = prod_abs[NUM_BITS-1:0];
        s6_den_next = span_abs[PULSE_BITS-1:0];
        s6_side_next.base      = s5_base_reg;
        s6_side_next.zero_span = (s5_span_reg == '0);
        s6_side_next.neg_quot  = s5_prod_reg[MAPP_BITS-1] ^ s5_span_reg[OFF_BITS-1];
        s6_side_next.dir       = s5_dir_reg;
    end

    // ---------------------------------------------------------------
    // Pipeline registers for stages 1 to 6
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mag_reg   <= s1_mag_next;
            s1_gain_reg  <= s1_gain_next;
            s1_below_reg <= s1_below_next;
            s2_prod_reg  <= s2_prod_next;
            s2_below_reg <= s1_below_reg;
            s3_v_reg     <= s3_v_next;
            s4_x_reg     <= s4_x_next;
            s4_span_reg  <= s4_span_next;
            s4_slope_reg <= s4_slope_next;
            s4_base_reg  <= s4_base_next;
            s4_dir_reg   <= s4_dir_next;
            s5_prod_reg  <= s5_prod_next;
            s5_span_reg  <= s4_span_reg;
            s5_base_reg  <= s4_base_reg;
            s5_dir_reg   <= s4_dir_reg;
            s6_num_reg   <= s6_num_next;
            s6_den_reg   <= s6_den_next;
            s6_side_reg  <= s6_side_next;
        end
    end

    // ---------------------------------------------------------------
    // Map divider: |product| / |span|, one bit per stage
    // ---------------------------------------------------------------
    logic                div_valid;
    logic [NUM_BITS-1:0] div_quot;
    epdm_side_t          div_side;

    epdm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_num    (s6_num_reg),
        .in_den    (s6_den_reg),
        .in_side   (s6_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ---------------------------------------------------------------
    // Output stage: apply sign, add base, final clamp
    // ---------------------------------------------------------------
    logic [PULSE_BITS-1:0] pulse_reg, pulse_next;
    logic [1:0]            dir_reg;

    logic signed [FIN_BITS-1:0] quot_s, fin, lo_f, hi_f;

    always_comb begin
        quot_s = signed'({2'b00, div_quot});
        if (div_side.zero_span) begin
            quot_s = '0;
        end else if (div_side.neg_quot) begin
            quot_s = -quot_s;
        end
        fin  = quot_s + signed'({{(FIN_BITS-BASE_BITS){1'b0}}, div_side.base});
        lo_f = signed'({{(FIN_BITS-PULSE_BITS){1'b0}}, min_reg});
        hi_f = signed'({{(FIN_BITS-PULSE_BITS){1'b0}}, max_reg});
        if (fin < lo_f) begin
            pulse_next = min_reg;
        end else if (fin > hi_f) begin
            pulse_next = max_reg;
        end else begin
            pulse_next = fin[PULSE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pulse_reg <= pulse_next;
            dir_reg   <= div_side.dir;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pulse_us  = pulse_reg;
    assign m_direction = dir_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted item did not enter stage 1");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_valid_reg) |=> s2_valid_reg)
        else $error("item lost between stage 1 and stage 2");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(s6_num_reg) && $stable(s6_valid_reg)))
        else $error("pipeline moved while the result was held");

endmodule
